/* rtl/otae_pkg.sv */
// Shared codes and table port types for the object tree attribute engine.
package otae_pkg;

   localparam int DefaultMaxObjects = 256;

   localparam logic [3:0] MODE_CHILD   = 4'd0;
   localparam logic [3:0] MODE_PARENT  = 4'd1;
   localparam logic [3:0] MODE_SIBLING = 4'd2;
   localparam logic [3:0] MODE_INSERT  = 4'd3;
   localparam logic [3:0] MODE_REMOVE  = 4'd4;
   localparam logic [3:0] MODE_JIN     = 4'd5;
   localparam logic [3:0] MODE_SET     = 4'd6;
   localparam logic [3:0] MODE_CLEAR   = 4'd7;
   localparam logic [3:0] MODE_TEST    = 4'd8;
   localparam logic [3:0] MODE_LOAD    = 4'd9;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_WARN_OBJ   = 3'd1;
   localparam logic [2:0] ST_BAD_OBJ    = 3'd2;
   localparam logic [2:0] ST_BAD_ATTR   = 3'd3;
   localparam logic [2:0] ST_INSIDE     = 3'd4;
   localparam logic [2:0] ST_LOOPED     = 3'd5;

   localparam logic [1:0] CSR_VERSION = 2'd0;
   localparam logic [1:0] CSR_COUNT   = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   localparam int AttrTopV4 = 47;
   localparam int AttrTopV3 = 31;

   typedef struct packed {
      logic [7:0]  parent;
      logic [7:0]  sibling;
      logic [7:0]  child;
      logic [47:0] attributes;
   } entry_type;

   typedef struct packed {
      logic        parent_we;
      logic        sibling_we;
      logic        child_we;
      logic        attr_we;
      logic [15:0] parent_addr;
      logic [15:0] sibling_addr;
      logic [15:0] child_addr;
      logic [15:0] attr_addr;
      entry_type   data;
   } table_wr_type;

endpackage

/* rtl/object_tree_attribute_engine_unit.sv */
// Top level: opcode sequencer over the object table.
// Usage: raise start with the req_ fields while busy is low; the transaction
// is taken at that edge and busy rises on the next cycle. Exactly one result
// follows on rsp_value, rsp_branch and rsp_status, marked by rsp_strobe for
// one cycle; the receiver cannot stall it. busy falls the cycle after.
// Link reads, jin and attribute opcodes go through dispatch, one table read
// and a result state; load and rejected opcodes skip the read. Remove
// walks the sibling list; insert first walks first-child links, then
// unlinks the object and writes the final links.
// Timing is set by the single registered table read port: every link
// followed costs a read state and a decide state.
// Configuration: csr_we writes csr_wdata to register csr_index at a rising
// edge; the user writes only while busy is low, the block does not enforce it.
// Reset clears the sequencer and configuration registers; the table holds
// no valid bits and entries must be loaded before they are read.
module object_tree_attribute_engine_unit import otae_pkg::*; #(
   parameter int MAX_OBJECTS = DefaultMaxObjects
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_object,
   input  logic [15:0] req_operand,
   input  logic [7:0]  req_load_parent,
   input  logic [7:0]  req_load_sibling,
   input  logic [7:0]  req_load_child,
   input  logic [47:0] req_load_attributes,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_value,
   output logic        rsp_branch,
   output logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_OBJECTS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_RDLINK = 4'd2;
   localparam logic [3:0] S_ATTR   = 4'd3;
   localparam logic [3:0] S_WALK   = 4'd4;
   localparam logic [3:0] S_WALK2  = 4'd5;
   localparam logic [3:0] S_RM0    = 4'd6;
   localparam logic [3:0] S_RM1    = 4'd7;
   localparam logic [3:0] S_RM2    = 4'd8;
   localparam logic [3:0] S_RML    = 4'd9;
   localparam logic [3:0] S_RML2   = 4'd10;
   localparam logic [3:0] S_RMFIN  = 4'd11;
   localparam logic [3:0] S_INS0   = 4'd12;
   localparam logic [3:0] S_INS1   = 4'd13;
   localparam logic [3:0] S_DONE   = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic        version_ff, version_in;
   logic [7:0]  count_cfg_ff, count_cfg_in;
   logic [7:0]  limit_ff, limit_in;
   logic [3:0]  mode_ff, mode_in;
   logic [7:0]  obj_ff, obj_in;
   logic [15:0] opnd_ff, opnd_in;
   entry_type   load_ff, load_in;
   logic [7:0]  link_ff, link_in;
   logic [7:0]  par_ff, par_in;
   logic [7:0]  osib_ff, osib_in;
   logic [8:0]  steps_ff, steps_in;
   logic [7:0]  value_ff, value_in;
   logic        branch_ff, branch_in;
   logic [2:0]  status_ff, status_in;

   logic [IDX_W-1:0] rd_addr;
   table_wr_type     wr;
   entry_type        rd_data;

   otae_table #(.MAX_OBJECTS(MAX_OBJECTS), .IDX_W(IDX_W)) u_table (
      .clock  (clock),
      .rd_addr(rd_addr),
      .wr     (wr),
      .rd_data(rd_data)
   );

   // Object number to table row, reduced modulo the table depth.
   function automatic logic [IDX_W-1:0] ix(input logic [7:0] n);
      logic [19:0] r;
      logic [19:0] m;
      r = {12'd0, n};
      for (int k = 3; k >= 0; k--) begin
         m = 20'(MAX_OBJECTS) << k;
         if (r >= m) r = r - m;
      end
      return r[IDX_W-1:0];
   endfunction

   function automatic logic [15:0] ax(input logic [7:0] n);
      return 16'(ix(n));
   endfunction

   // Range check code of an object number: ok, warning or bad.
   function automatic logic [2:0] obj_code(input logic [15:0] n,
                                           input logic [7:0] cnt,
                                           input logic [7:0] lim);
      logic [2:0] c;
      c = ST_OK;
      if (n > {8'd0, cnt}) c = (n > {8'd0, lim}) ? ST_BAD_OBJ : ST_WARN_OBJ;
      if (n == 16'd0) c = ST_BAD_OBJ;
      return c;
   endfunction

   // Keep the first error; a warning only upgrades a clean status.
   function automatic logic [2:0] note(input logic [2:0] st, input logic [2:0] code);
      logic [2:0] r;
      r = st;
      if (code == ST_WARN_OBJ) begin
         if (st == ST_OK) r = ST_WARN_OBJ;
      end else if (code != ST_OK) begin
         if (st < ST_BAD_OBJ) r = code;
      end
      return r;
   endfunction

   logic [2:0]  code_a, code_b;
   logic [2:0]  st_a, st_b;
   logic [5:0]  attr_pos;
   logic [47:0] attr_bit;
   logic        attr_good;

   always_comb begin
      state_in     = state_ff;
      version_in   = version_ff;
      count_cfg_in = count_cfg_ff;
      limit_in     = limit_ff;
      mode_in      = mode_ff;
      obj_in       = obj_ff;
      opnd_in      = opnd_ff;
      load_in      = load_ff;
      link_in      = link_ff;
      par_in       = par_ff;
      osib_in      = osib_ff;
      steps_in     = steps_ff;
      value_in     = value_ff;
      branch_in    = branch_ff;
      status_in    = status_ff;
      rd_addr      = ix(obj_ff);
      wr           = '0;
      wr.data      = load_ff;
      code_a       = obj_code({8'd0, obj_ff}, count_cfg_ff, limit_ff);
      code_b       = obj_code(opnd_ff, count_cfg_ff, limit_ff);
      st_a         = note(status_ff, code_a);
      st_b         = note(st_a, code_b);
      attr_good    = opnd_ff <= (version_ff ? 16'(AttrTopV4) : 16'(AttrTopV3));
      attr_pos     = 6'(AttrTopV4) - opnd_ff[5:0];
      attr_bit     = 48'd1 << attr_pos;

      if (csr_we) begin
         unique case (csr_index)
            CSR_VERSION: version_in   = csr_wdata[0];
            CSR_COUNT:   count_cfg_in = csr_wdata;
            CSR_LIMIT:   limit_in     = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in            = req_mode;
               obj_in             = req_object;
               opnd_in            = req_operand;
               load_in.parent     = req_load_parent;
               load_in.sibling    = req_load_sibling;
               load_in.child      = req_load_child;
               load_in.attributes = req_load_attributes;
               value_in           = 8'd0;
               branch_in          = 1'b0;
               status_in          = ST_OK;
               state_in           = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            case (mode_ff) inside
               MODE_CHILD, MODE_PARENT, MODE_SIBLING, MODE_JIN: begin
                  status_in = st_a;
                  if (code_a != ST_BAD_OBJ) state_in = S_RDLINK;
               end
               MODE_SET, MODE_CLEAR, MODE_TEST: begin
                  status_in = st_a;
                  if (code_a != ST_BAD_OBJ) begin
                     if (attr_good) state_in = S_ATTR;
                     else status_in = note(st_a, ST_BAD_ATTR);
                  end
               end
               MODE_LOAD: begin
                  wr.parent_we    = 1'b1;
                  wr.sibling_we   = 1'b1;
                  wr.child_we     = 1'b1;
                  wr.attr_we      = 1'b1;
                  wr.parent_addr  = ax(obj_ff);
                  wr.sibling_addr = ax(obj_ff);
                  wr.child_addr   = ax(obj_ff);
                  wr.attr_addr    = ax(obj_ff);
               end
               MODE_INSERT: begin
                  if (code_a == ST_BAD_OBJ) begin
                     status_in = st_a;
                  end else begin
                     status_in = st_b;
                     if (code_b != ST_BAD_OBJ) begin
                        link_in  = obj_ff;
                        steps_in = 9'd0;
                        state_in = S_WALK;
                     end
                  end
               end
               MODE_REMOVE: state_in = S_RM0;
               default: ;
            endcase
         end
         S_RDLINK: begin
            state_in = S_DONE;
            case (mode_ff)
               MODE_CHILD: begin
                  value_in  = rd_data.child;
                  branch_in = rd_data.child != 8'd0;
               end
               MODE_PARENT: value_in = rd_data.parent;
               MODE_SIBLING: begin
                  value_in  = rd_data.sibling;
                  branch_in = rd_data.sibling != 8'd0;
               end
               default: branch_in = {8'd0, rd_data.parent} == opnd_ff;
            endcase
         end
         S_ATTR: begin
            state_in     = S_DONE;
            wr.attr_addr = ax(obj_ff);
            case (mode_ff)
               MODE_SET: begin
                  wr.attr_we         = 1'b1;
                  wr.data.attributes = rd_data.attributes | attr_bit;
               end
               MODE_CLEAR: begin
                  wr.attr_we         = 1'b1;
                  wr.data.attributes = rd_data.attributes & ~attr_bit;
               end
               default: branch_in = rd_data.attributes[attr_pos];
            endcase
         end
         S_WALK: begin
            rd_addr = ix(link_ff);
            if (link_ff == 8'd0) begin
               state_in = S_RM0;
            end else if ({8'd0, link_ff} == opnd_ff) begin
               status_in = note(status_ff, ST_INSIDE);
               state_in  = S_DONE;
            end else begin
               state_in = S_WALK2;
            end
         end
         S_WALK2: begin
            link_in  = rd_data.child;
            steps_in = steps_ff + 9'd1;
            if (steps_ff + 9'd1 > {1'b0, limit_ff}) begin
               status_in = note(status_ff, ST_LOOPED);
               state_in  = S_RM0;
            end else begin
               state_in = S_WALK;
            end
         end
         S_RM0: begin
            status_in = st_a;
            rd_addr   = ix(obj_ff);
            if (code_a == ST_BAD_OBJ)
               state_in = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
            else
               state_in = S_RM1;
         end
         S_RM1: begin
            par_in  = rd_data.parent;
            osib_in = rd_data.sibling;
            rd_addr = ix(rd_data.parent);
            code_a  = obj_code({8'd0, rd_data.parent}, count_cfg_ff, limit_ff);
            if (rd_data.parent == 8'd0) begin
               state_in = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
            end else begin
               status_in = note(status_ff, code_a);
               if (code_a == ST_BAD_OBJ)
                  state_in = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
               else
                  state_in = S_RM2;
            end
         end
         S_RM2: begin
            if (rd_data.child == obj_ff) begin
               wr.child_we      = 1'b1;
               wr.child_addr    = ax(par_ff);
               wr.data.child    = osib_ff;
               state_in         = S_RMFIN;
            end else begin
               link_in  = rd_data.child;
               steps_in = 9'd0;
               state_in = S_RML;
            end
         end
         S_RML: begin
            code_a    = obj_code({8'd0, link_ff}, count_cfg_ff, limit_ff);
            status_in = note(status_ff, code_a);
            rd_addr   = ix(link_ff);
            if (code_a == ST_BAD_OBJ)
               state_in = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
            else
               state_in = S_RML2;
         end
         S_RML2: begin
            steps_in = steps_ff + 9'd1;
            if (steps_ff > {1'b0, limit_ff}) begin
               status_in = note(status_ff, ST_LOOPED);
               state_in  = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
            end else if (rd_data.sibling == obj_ff) begin
               wr.sibling_we   = 1'b1;
               wr.sibling_addr = ax(link_ff);
               wr.data.sibling = osib_ff;
               state_in        = S_RMFIN;
            end else begin
               link_in  = rd_data.sibling;
               state_in = S_RML;
            end
         end
         S_RMFIN: begin
            wr.parent_we    = 1'b1;
            wr.sibling_we   = 1'b1;
            wr.parent_addr  = ax(obj_ff);
            wr.sibling_addr = ax(obj_ff);
            wr.data.parent  = 8'd0;
            wr.data.sibling = 8'd0;
            state_in = (mode_ff == MODE_INSERT) ? S_INS0 : S_DONE;
         end
         S_INS0: begin
            rd_addr  = ix(opnd_ff[7:0]);
            state_in = S_INS1;
         end
         S_INS1: begin
            wr.parent_we    = 1'b1;
            wr.sibling_we   = 1'b1;
            wr.child_we     = 1'b1;
            wr.parent_addr  = ax(obj_ff);
            wr.sibling_addr = ax(obj_ff);
            wr.child_addr   = ax(opnd_ff[7:0]);
            wr.data.parent  = opnd_ff[7:0];
            wr.data.sibling = rd_data.child;
            wr.data.child   = obj_ff;
            state_in        = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         version_ff   <= 1'b0;
         count_cfg_ff <= 8'd0;
         limit_ff     <= 8'd0;
      end else begin
         state_ff     <= state_in;
         version_ff   <= version_in;
         count_cfg_ff <= count_cfg_in;
         limit_ff     <= limit_in;
      end
      mode_ff   <= mode_in;
      obj_ff    <= obj_in;
      opnd_ff   <= opnd_in;
      load_ff   <= load_in;
      link_ff   <= link_in;
      par_ff    <= par_in;
      osib_ff   <= osib_in;
      steps_ff  <= steps_in;
      value_ff  <= value_in;
      branch_ff <= branch_in;
      status_ff <= status_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;
   assign rsp_value  = value_ff;
   assign rsp_branch = branch_ff;
   assign rsp_status = status_ff;

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("result strobe not followed by idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe) else $error("transaction not taken");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= ST_LOOPED) else $error("status out of range");
   a_branch_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_branch |-> rsp_status == ST_OK || rsp_status == ST_WARN_OBJ)
      else $error("branch with an error status");

endmodule

/* rtl/otae_table.sv */
// Link and attribute table memories with one read address and registered read data.
module otae_table import otae_pkg::*; #(
   parameter int MAX_OBJECTS = DefaultMaxObjects,
   parameter int IDX_W = $clog2(MAX_OBJECTS)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   input  table_wr_type     wr,
   output entry_type        rd_data
);

   logic [7:0]  parent_mem  [MAX_OBJECTS];
   logic [7:0]  sibling_mem [MAX_OBJECTS];
   logic [7:0]  child_mem   [MAX_OBJECTS];
   logic [47:0] attr_mem    [MAX_OBJECTS];

   always_ff @(posedge clock) begin
      if (wr.parent_we) parent_mem[wr.parent_addr[IDX_W-1:0]] <= wr.data.parent;
      if (wr.sibling_we) sibling_mem[wr.sibling_addr[IDX_W-1:0]] <= wr.data.sibling;
      if (wr.child_we) child_mem[wr.child_addr[IDX_W-1:0]] <= wr.data.child;
      if (wr.attr_we) attr_mem[wr.attr_addr[IDX_W-1:0]] <= wr.data.attributes;
      rd_data.parent     <= parent_mem[rd_addr];
      rd_data.sibling    <= sibling_mem[rd_addr];
      rd_data.child      <= child_mem[rd_addr];
      rd_data.attributes <= attr_mem[rd_addr];
   end

endmodule

/* tb/sv/object_tree_attribute_engine_checker.sv */
// Checker: predicts each object table transaction and compares the results.
module object_tree_attribute_engine_checker import otae_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_object,
   input  logic [15:0] req_operand,
   input  logic [7:0]  req_load_parent,
   input  logic [7:0]  req_load_sibling,
   input  logic [7:0]  req_load_child,
   input  logic [47:0] req_load_attributes,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_value,
   input  logic        rsp_branch,
   input  logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);

   typedef struct packed {
      logic [7:0] value;
      logic       branch;
      logic [2:0] status;
   } outcome_type;

   logic [7:0]  parent_tab [256];
   logic [7:0]  sibling_tab[256];
   logic [7:0]  child_tab  [256];
   logic [47:0] attr_tab   [256];

   logic       wide_attrs;
   logic [7:0] count_reg;
   logic [7:0] limit_reg;
   logic [2:0] flag;

   outcome_type outcome_q[$];

   assign pending = outcome_q.size();

   function automatic void raise_flag(logic [2:0] code);
      if (code == ST_WARN_OBJ) begin
         if (flag == ST_OK) flag = ST_WARN_OBJ;
      end else if (flag < ST_BAD_OBJ) begin
         flag = code;
      end
   endfunction

   function automatic bit object_valid(int n);
      if (n > count_reg) begin
         if (n > limit_reg) begin
            raise_flag(ST_BAD_OBJ);
            return 0;
         end
         raise_flag(ST_WARN_OBJ);
      end
      if (n == 0) begin
         raise_flag(ST_BAD_OBJ);
         return 0;
      end
      return 1;
   endfunction

   function automatic void unlink_object(int obj);
      int par;
      int cur;
      int nxt;
      int steps;
      steps = 0;
      cur = 0;
      if (!object_valid(obj)) return;
      par = parent_tab[obj % 256];
      if (par == 0) return;
      if (!object_valid(par)) return;
      nxt = child_tab[par % 256];
      if (nxt == obj) begin
         child_tab[par % 256] = sibling_tab[obj % 256];
      end else begin
         do begin
            cur = nxt;
            if (!object_valid(cur)) return;
            nxt = sibling_tab[cur % 256];
            if (steps > limit_reg) begin
               raise_flag(ST_LOOPED);
               return;
            end
            steps++;
         end while (nxt != obj);
         sibling_tab[cur % 256] = sibling_tab[obj % 256];
      end
      parent_tab[obj % 256]  = 8'd0;
      sibling_tab[obj % 256] = 8'd0;
   endfunction

   function automatic void move_object(int obj, int dest);
      int walk;
      int depth;
      walk = obj;
      depth = 0;
      if (!object_valid(obj)) return;
      if (!object_valid(dest)) return;
      while (walk != 0) begin
         if (walk == dest) begin
            raise_flag(ST_INSIDE);
            return;
         end
         walk = child_tab[walk % 256];
         depth++;
         if (depth > limit_reg) begin
            raise_flag(ST_LOOPED);
            break;
         end
      end
      unlink_object(obj);
      parent_tab[obj % 256]  = dest[7:0];
      sibling_tab[obj % 256] = child_tab[dest % 256];
      child_tab[dest % 256]  = obj[7:0];
   endfunction

   function automatic outcome_type run_opcode();
      outcome_type res;
      int obj;
      int opnd;
      int top;
      logic [47:0] mask;
      res = '0;
      flag = ST_OK;
      obj = req_object;
      opnd = req_operand;
      top = wide_attrs ? AttrTopV4 : AttrTopV3;
      case (req_mode) inside
         MODE_CHILD, MODE_PARENT, MODE_SIBLING: begin
            if (object_valid(obj)) begin
               if (req_mode == MODE_CHILD) res.value = child_tab[obj];
               else if (req_mode == MODE_PARENT) res.value = parent_tab[obj];
               else res.value = sibling_tab[obj];
               if (req_mode != MODE_PARENT) res.branch = (res.value != 8'd0);
            end
         end
         MODE_INSERT: move_object(obj, opnd);
         MODE_REMOVE: unlink_object(obj);
         MODE_JIN: begin
            if (object_valid(obj)) res.branch = (int'(parent_tab[obj]) == opnd);
         end
         MODE_SET, MODE_CLEAR, MODE_TEST: begin
            if (object_valid(obj)) begin
               if (opnd > top) begin
                  raise_flag(ST_BAD_ATTR);
               end else begin
                  mask = 48'd1 << (47 - opnd);
                  if (req_mode == MODE_SET) attr_tab[obj] |= mask;
                  else if (req_mode == MODE_CLEAR) attr_tab[obj] &= ~mask;
                  else res.branch = ((attr_tab[obj] & mask) != 48'd0);
               end
            end
         end
         MODE_LOAD: begin
            parent_tab[obj]  = req_load_parent;
            sibling_tab[obj] = req_load_sibling;
            child_tab[obj]   = req_load_child;
            attr_tab[obj]    = req_load_attributes;
         end
         default: ;
      endcase
      res.status = flag;
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         wide_attrs <= 1'b0;
         count_reg <= 8'd0;
         limit_reg <= 8'd0;
         fail_count = 0;
         results_seen = 0;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VERSION: wide_attrs <= csr_wdata[0];
               CSR_COUNT:   count_reg <= csr_wdata;
               CSR_LIMIT:   limit_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) outcome_q.push_back(run_opcode());
         if (rsp_strobe) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
               $error("result with no transaction outstanding");
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_branch !== want.branch) begin
                  $error("branch: expected %0d, got %0d", want.branch, rsp_branch);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

/* tb/sv/object_tree_attribute_engine_unit_test.sv */
// Testbench top: drives opcodes and configuration, gives the verdict.
module object_tree_attribute_engine_unit_test;
   import otae_pkg::*;

   localparam int WatchdogLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_mode = MODE_LOAD;
   logic [7:0]  req_object = '0;
   logic [15:0] req_operand = '0;
   logic [7:0]  req_load_parent = '0;
   logic [7:0]  req_load_sibling = '0;
   logic [7:0]  req_load_child = '0;
   logic [47:0] req_load_attributes = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_value;
   logic        rsp_branch;
   logic [2:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_VERSION;
   logic [7:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int results_seen;
   int idle_cycles = 0;
   int idle_pct = 0;
   int obj_top = 1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   object_tree_attribute_engine_unit i_dut (.*);

   object_tree_attribute_engine_checker i_checker (.*);

   // Stall watchdog: any handshake or result resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue(logic [3:0] m, logic [7:0] o, logic [15:0] opnd,
                        logic [7:0] lp = 0, logic [7:0] ls = 0, logic [7:0] lc = 0,
                        logic [47:0] la = 0);
      req_mode <= m;
      req_object <= o;
      req_operand <= opnd;
      req_load_parent <= lp;
      req_load_sibling <= ls;
      req_load_child <= lc;
      req_load_attributes <= la;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      // drop start for a random gap on the configured share of transactions
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic v4, logic [7:0] cnt, logic [7:0] lim);
      drain();
      write_csr(CSR_VERSION, {7'd0, v4});
      write_csr(CSR_COUNT, cnt);
      write_csr(CSR_LIMIT, lim);
      obj_top = (lim < 253) ? lim + 2 : 255;
      if (obj_top < 2) obj_top = 2;
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic random_item();
      int pick;
      logic [7:0] o;
      logic [15:0] opnd;
      pick = $urandom_range(99);
      o = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(obj_top));
      opnd = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(obj_top));
      if (pick < 22) issue(MODE_INSERT, o, opnd);
      else if (pick < 36) issue(MODE_REMOVE, o, '0);
      else if (pick < 54) issue(4'($urandom_range(MODE_CHILD, MODE_SIBLING)), o, '0);
      else if (pick < 62) issue(MODE_JIN, o, opnd);
      else if (pick < 88) begin
         opnd = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(50));
         issue(4'($urandom_range(MODE_SET, MODE_TEST)), o, opnd);
      end else if (pick < 96) begin
         // scrambled entry: arbitrary links, possibly loops
         issue(MODE_LOAD, o, 16'($urandom), 8'($urandom_range(obj_top)),
               8'($urandom_range(obj_top)), 8'($urandom_range(obj_top)), rand48());
      end else begin
         issue(4'($urandom_range(10, 15)), o, 16'($urandom));
      end
   endtask

   initial begin
      logic [7:0] setting [5][3];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry written before anything reads it
      for (int n = 0; n < 256; n++) issue(MODE_LOAD, 8'(n), '0, 0, 0, 0, rand48());
      issue(MODE_LOAD, 8'd255, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
      issue(MODE_LOAD, 8'd255, '0, 0, 0, 0, '0);

      configure(1'b1, 8'd255, 8'd255);
      issue(MODE_CHILD, 8'd0, '0);
      issue(MODE_INSERT, 8'd1, 16'd2);
      issue(MODE_INSERT, 8'd3, 16'd2);
      issue(MODE_CHILD, 8'd2, '0);
      issue(MODE_PARENT, 8'd1, '0);
      issue(MODE_SIBLING, 8'd3, '0);
      issue(MODE_JIN, 8'd1, 16'd2);
      issue(MODE_INSERT, 8'd2, 16'd1);
      issue(MODE_REMOVE, 8'd1, '0);
      issue(MODE_REMOVE, 8'd4, '0);
      issue(MODE_SET, 8'd5, 16'd0);
      issue(MODE_SET, 8'd5, 16'd47);
      issue(MODE_TEST, 8'd5, 16'd47);
      issue(MODE_CLEAR, 8'd5, 16'd0);
      issue(MODE_TEST, 8'd5, 16'd48);
      issue(MODE_INSERT, 8'd6, 16'hFFFF);
      // self-looped child chain and self-looped sibling list
      issue(MODE_LOAD, 8'd7, '0, 0, 0, 8'd7);
      issue(MODE_INSERT, 8'd7, 16'd8);
      issue(MODE_LOAD, 8'd9, '0, 8'd10, 0, 0);
      issue(MODE_LOAD, 8'd10, '0, 0, 0, 8'd11);
      issue(MODE_LOAD, 8'd11, '0, 8'd10, 8'd11, 0);
      issue(MODE_REMOVE, 8'd9, '0);
      issue(MODE_TEST, 8'd200, 16'd20);
      issue(4'd12, 8'd1, 16'd1);

      configure(1'b0, 8'd100, 8'd200);
      issue(MODE_SET, 8'd150, 16'd31);
      issue(MODE_SET, 8'd150, 16'd32);
      issue(MODE_PARENT, 8'd201, '0);
      configure(1'b0, 8'd0, 8'd0);
      issue(MODE_CHILD, 8'd1, '0);

      setting = '{'{1, 255, 255}, '{0, 100, 200}, '{1, 20, 40},
                  '{0, 255, 12}, '{1, 0, 255}};
      for (int k = 0; k < 2000; k++) begin
         if (k % 400 == 0)
            configure(setting[k / 400][0][0], setting[k / 400][1], setting[k / 400][2]);
         idle_pct = (k < 667) ? 24 : (k < 1333) ? 75 : 0;
         if (k == 1000) drain();
         random_item();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d results: link reads, insert, remove, jin and attributes",
               results_seen);
      $display("over eight register configurations, including looped and broken link chains.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
